FILE: hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types for the sorted list block
// Request and response payloads, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef struct packed {
		logic               command;
		logic [VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic                   accepted;
		logic [COUNT_OUT_W-1:0] entry_count;
	} response_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} ctrl_t;

	typedef struct packed {
		logic rsp_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: sorted list of distinct signed values
// Insert and delete requests on a fixed-capacity list kept in ascending or
// descending order; each request returns an accepted flag and the count.
//
//   channel  direction  payload     handshake
//   cmd      in         request_t   cmd_valid / cmd_ready
//   rsp      out        response_t  rsp_valid / rsp_ready
//   cfg      in         order bit   cfg_valid / cfg_ready
//
// A request passes through accept, compare in every cell and update.
// The next request is accepted in the cycle after the update, so a new
// request enters only once the previous one has been through update.
// A stalled response holds the update until the response register frees.
// Reset empties the list and selects ascending order; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete #(
	parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  sli_pkg::request_t  cmd_data,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output sli_pkg::response_t rsp_data,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_data
);
	import sli_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	sli_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl: request sequencer
// Steps each request through accept, compare and update, and holds the
// update while the response register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_ready,
	input  sli_pkg::stat_t stat,
	output sli_pkg::ctrl_t ctrl
);
	import sli_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (stat.rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_ready    = 1'b0;
		ctrl.load    = 1'b0;
		ctrl.compare = 1'b0;
		ctrl.update  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctrl.load = cmd_valid;
			end
			ST_CMP: begin
				ctrl.compare = 1'b1;
			end
			ST_UPD: begin
				ctrl.update = stat.rsp_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath: entry cells, comparators and response register
// Every cell compares its entry with the request value; the first cell that
// does not precede the value marks the slot, and the cells from the slot up shift together.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_datapath #(
	parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
	input  wire                clk,
	input  wire                arst_n,
	input  sli_pkg::request_t  cmd_data,
	input  wire                cfg_valid,
	input  wire                cfg_data,
	input  wire                rsp_ready,
	output logic               rsp_valid,
	output sli_pkg::response_t rsp_data,
	input  sli_pkg::ctrl_t     ctrl,
	output sli_pkg::stat_t     stat
);
	import sli_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic                      order_q;
	logic                      cmd_q;
	logic signed [VALUE_W-1:0] x_q;
	logic signed [VALUE_W-1:0] entry_q [CAPACITY];
	logic signed [VALUE_W-1:0] entry_d [CAPACITY];
	logic [CAPACITY-1:0]       valid_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [CAPACITY-1:0]       after_s1;
	logic [CAPACITY-1:0]       eq_s1;
	logic [CAPACITY-1:0]       after_c;
	logic [CAPACITY-1:0]       eq_c;
	logic [CAPACITY-1:0]       carry;
	logic [CAPACITY-1:0]       slot;
	logic [CAPACITY-1:0]       below;
	logic                      match;
	logic                      full;
	logic                      ok;
	logic [CW+COUNT_OUT_W-1:0] count_ext;
	response_t                 rsp_q;
	logic                      rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid) begin
			order_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_data.command;
			x_q   <= $signed(cmd_data.value);
		end
	end

	genvar k;
	generate
		for (k = 0; k < CAPACITY; k++) begin : g_cell
			assign after_c[k] = valid_q[k] &&
				(order_q ? (x_q < entry_q[k]) : (x_q > entry_q[k]));
			assign eq_c[k] = valid_q[k] && (x_q == entry_q[k]);

			if (k == 0) begin : g_first
				always_comb begin
					entry_d[k] = entry_q[k];
					if (cmd_q == CMD_INSERT) begin
						if (!below[k]) begin
							entry_d[k] = x_q;
						end
					end else if (!below[k] && CAPACITY > 1) begin
						entry_d[k] = entry_q[(k + 1) % CAPACITY];
					end
				end
			end else if (k == CAPACITY - 1) begin : g_last
				always_comb begin
					entry_d[k] = entry_q[k];
					if (cmd_q == CMD_INSERT && !below[k]) begin
						entry_d[k] = slot[k] ? x_q : entry_q[k-1];
					end
				end
			end else begin : g_mid
				always_comb begin
					entry_d[k] = entry_q[k];
					if (!below[k]) begin
						if (cmd_q == CMD_INSERT) begin
							entry_d[k] = slot[k] ? x_q : entry_q[k-1];
						end else begin
							entry_d[k] = entry_q[k+1];
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (ctrl.update && ok) begin
					entry_q[k] <= entry_d[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			after_s1 <= after_c;
			eq_s1    <= eq_c;
		end
	end

	assign carry = after_s1 + {{(CAPACITY-1){1'b0}}, 1'b1};
	assign slot  = ~after_s1 & carry;
	assign below = after_s1 & ~carry;
	assign match = |(eq_s1 & slot);
	assign full  = valid_q[CAPACITY-1];
	assign ok    = (cmd_q == CMD_INSERT) ? (!full && !match) : match;

	always_comb begin
		count_d = count_q;
		if (ok) begin
			if (cmd_q == CMD_INSERT) begin
				count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
			end else begin
				count_d = count_q - {{(CW-1){1'b0}}, 1'b1};
			end
		end
	end

	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (ctrl.update && ok) begin
			count_q <= count_d;
			if (cmd_q == CMD_INSERT) begin
				valid_q <= {valid_q[CAPACITY-2:0], 1'b1};
			end else begin
				valid_q <= {1'b0, valid_q[CAPACITY-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.update) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			rsp_q.accepted    <= ok;
			rsp_q.entry_count <= count_ext[COUNT_OUT_W-1:0];
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp_data      = rsp_q;
	assign stat.rsp_free = !rsp_valid_q || rsp_ready;

endmodule

`default_nettype wire
